// ===== src/fnavg_pkg.sv =====
// Shared types, widths and codes for the fixed-radius neighbour average block.
// No dependencies; imported by every module of the block.
package fnavg_pkg;

  localparam int COORD_W             = 16;
  localparam int INDEX_W             = 6;
  localparam int INDEX_SPAN          = 2 ** INDEX_W;
  localparam int RADIUS_W            = 16;
  localparam int DEFAULT_AGENT_COUNT = 64;
  localparam int CFG_ADDR_W          = 3;
  localparam int CFG_DATA_W          = 32;
  localparam int AVG_LANES           = 4;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd240;

  // Command codes on the request channel
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_RADIUS = 1'b0;

  // One stored coordinate pair: x in the low half, y in the high half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec2_t;

  // Sequencer to scan pipeline
  typedef struct packed {
    logic clear;    // new query: clear sums, latch radius squared
    logic capture;  // store read data is the queried agent's entry
    logic issue;    // a table entry is being read this cycle
    logic hit_tag;  // that entry is valid and is not the queried agent
  } scan_ctrl_t;

endpackage

// ===== src/fnavg_store.sv =====
// Agent table: position and velocity memories, one write and one read port.
// Read data is registered. Depends on fnavg_pkg.
module fnavg_store import fnavg_pkg::*; #(
  parameter int  SLOT_COUNT = DEFAULT_AGENT_COUNT,
  localparam int ADDR_W     = $clog2(SLOT_COUNT)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  vec2_t             wpos,
  input  vec2_t             wvel,
  input  logic [ADDR_W-1:0] raddr,
  output vec2_t             rpos,
  output vec2_t             rvel
);

  vec2_t pos_mem [SLOT_COUNT];
  vec2_t vel_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr] <= wpos;
      vel_mem[waddr] <= wvel;
    end
  end

  always_ff @(posedge clk) begin
    rpos <= pos_mem[raddr];
    rvel <= vel_mem[raddr];
  end

endmodule

// ===== src/fnavg_scan.sv =====
// Distance test and accumulation pipeline fed from the agent table read port.
// Stages: square the offsets, add and compare with radius squared, accumulate.
// Depends on fnavg_pkg.
module fnavg_scan import fnavg_pkg::*; #(
  parameter int  CNT_W = INDEX_W,
  localparam int SUM_W = COORD_W + CNT_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  scan_ctrl_t              ctrl,
  input  logic [RADIUS_W-1:0]     radius,
  input  vec2_t                   rpos,
  input  vec2_t                   rvel,
  output logic                    pending,
  output logic [CNT_W-1:0]        count,
  output logic signed [SUM_W-1:0] sum_px,
  output logic signed [SUM_W-1:0] sum_py,
  output logic signed [SUM_W-1:0] sum_vx,
  output logic signed [SUM_W-1:0] sum_vy
);

  logic                       [2*RADIUS_W-1:0] r2;
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;

  // read stage
  logic a_valid;
  logic a_tag;
  // square stage
  logic                 b_valid;
  logic                 b_tag;
  logic [2*COORD_W-1:0] b_sqx;
  logic [2*COORD_W-1:0] b_sqy;
  vec2_t                b_pos;
  vec2_t                b_vel;
  // compare stage
  logic  c_valid;
  logic  c_hit;
  vec2_t c_pos;
  vec2_t c_vel;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] sqx;
  logic signed [2*COORD_W+1:0] sqy;
  logic        [2*COORD_W:0]   sq_sum;

  always_comb begin
    dx     = $signed({rpos.x[COORD_W-1], rpos.x}) - $signed({qx[COORD_W-1], qx});
    dy     = $signed({rpos.y[COORD_W-1], rpos.y}) - $signed({qy[COORD_W-1], qy});
    sqx    = dx * dx;
    sqy    = dy * dy;
    sq_sum = {1'b0, b_sqx} + {1'b0, b_sqy};
  end

  assign pending = a_valid | b_valid | c_valid;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      r2 <= radius * radius;
    end
    if (ctrl.capture) begin
      qx <= rpos.x;
      qy <= rpos.y;
    end
    b_tag <= a_tag;
    b_sqx <= sqx[2*COORD_W-1:0];
    b_sqy <= sqy[2*COORD_W-1:0];
    b_pos <= rpos;
    b_vel <= rvel;
    c_hit <= b_valid && b_tag && (sq_sum <= {1'b0, r2});
    c_pos <= b_pos;
    c_vel <= b_vel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_tag   <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= ctrl.issue;
      a_tag   <= ctrl.issue & ctrl.hit_tag;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count  <= '0;
      sum_px <= '0;
      sum_py <= '0;
      sum_vx <= '0;
      sum_vy <= '0;
    end else if (c_valid && c_hit) begin
      count  <= count + 1'b1;
      sum_px <= sum_px + {{CNT_W{c_pos.x[COORD_W-1]}}, c_pos.x};
      sum_py <= sum_py + {{CNT_W{c_pos.y[COORD_W-1]}}, c_pos.y};
      sum_vx <= sum_vx + {{CNT_W{c_vel.x[COORD_W-1]}}, c_vel.x};
      sum_vy <= sum_vy + {{CNT_W{c_vel.y[COORD_W-1]}}, c_vel.y};
    end
  end

endmodule

// ===== src/fnavg_div.sv =====
// Restoring divider, one quotient bit a cycle: signed sum by unsigned count,
// truncated toward zero, low coordinate bits returned. Depends on fnavg_pkg.
module fnavg_div import fnavg_pkg::*; #(
  parameter int  CNT_W  = INDEX_W,
  localparam int SUM_W  = COORD_W + CNT_W,
  localparam int STEP_W = $clog2(SUM_W + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic [COORD_W-1:0]      quotient,
  output logic                    done
);

  logic [STEP_W-1:0] steps;
  logic              neg;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;

  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             take;
  logic [SUM_W-1:0] signed_quo;

  always_comb begin
    shifted    = {rem, quo[SUM_W-1]};
    diff       = shifted - {1'b0, dsr};
    take       = shifted >= {1'b0, dsr};
    signed_quo = neg ? (~quo + 1'b1) : quo;
    quotient   = signed_quo[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[SUM_W-2:0], take};
      rem <= take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1));
      if (start) begin
        steps <= STEP_W'(SUM_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
      end
    end
  end

endmodule

// ===== src/fixed_radius_neighbor_average.sv =====
// Top level of the fixed-radius neighbour average block: sequencer, register
// port, valid marks and result registers. Depends on fnavg_pkg, fnavg_store,
// fnavg_scan and fnavg_div.
//
// Usage:
//   Request channel: drive command, agent_index and the four entry fields and
//   raise start; the request is taken at the clock edge where start is high
//   and busy is low. A write request stores one agent's entry and gives no
//   result; busy stays low, so writes can follow each other every cycle. A
//   query request raises busy until its result is ready.
//   Result channel: done is high for exactly one cycle with neighbor_count,
//   the four truncated averages and no_neighbors; the receiver cannot stall.
//   busy is low again in that cycle, so the next request may be taken then.
//   A query takes these steps in order: a lookup step reads the queried
//   entry, the walk reads the whole table (64 entries by default), one read
//   per entry, the drain step waits until the scan pipeline is empty, and
//   the four dividers run side by side, one quotient bit a cycle. A query of
//   an agent never written, or out of range, skips the walk and goes straight
//   to the divide step, which raises done with no neighbours.
//   Register port: radius at byte address 0 over APB; pready is always high.
//   Write the radius only while busy is low.
//   Reset: clears all valid marks, the radius to 15.0 units and the sequencer;
//   table contents are not cleared and need no clearing pass.
module fixed_radius_neighbor_average import fnavg_pkg::*; #(
  parameter int AGENT_COUNT = DEFAULT_AGENT_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [INDEX_W-1:0]          agent_index,
  input  logic signed [COORD_W-1:0]   pos_x,
  input  logic signed [COORD_W-1:0]   pos_y,
  input  logic signed [COORD_W-1:0]   vel_x,
  input  logic signed [COORD_W-1:0]   vel_y,
  // result channel
  output logic                        done,
  output logic [INDEX_W-1:0]          neighbor_count,
  output logic signed [COORD_W-1:0]   avg_pos_x,
  output logic signed [COORD_W-1:0]   avg_pos_y,
  output logic signed [COORD_W-1:0]   avg_vel_x,
  output logic signed [COORD_W-1:0]   avg_vel_y,
  output logic                        no_neighbors,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_ADDR_W-1:0]       paddr,
  input  logic [CFG_DATA_W-1:0]       pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  // Only entries reachable by the index field are ever written
  localparam int SLOT_COUNT = (AGENT_COUNT < INDEX_SPAN) ? AGENT_COUNT : INDEX_SPAN;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = ADDR_W;
  localparam int SUM_W      = COORD_W + CNT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOKUP = 5'b00010,
    S_WALK   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_DIVIDE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [RADIUS_W-1:0]   radius;
  logic [SLOT_COUNT-1:0] valid;
  logic [ADDR_W-1:0]     qaddr;
  logic [ADDR_W-1:0]     walk;

  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] agent_addr;
  logic              store_we;
  logic [ADDR_W-1:0] raddr;
  vec2_t             rpos;
  vec2_t             rvel;
  scan_ctrl_t        ctrl;
  logic              pending;
  logic              div_start;
  logic              finish;
  logic              cfg_write;

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum_px;
  logic signed [SUM_W-1:0] sum_py;
  logic signed [SUM_W-1:0] sum_vx;
  logic signed [SUM_W-1:0] sum_vy;
  logic signed [SUM_W-1:0] div_num [AVG_LANES];
  logic [COORD_W-1:0]      div_q   [AVG_LANES];
  logic [AVG_LANES-1:0]    div_done;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign in_range   = (int'(agent_index) < SLOT_COUNT);
  assign agent_addr = agent_index[ADDR_W-1:0];
  assign store_we   = accept && (command == CMD_WRITE) && in_range;
  // Walk the table in order; otherwise point at the queried entry
  assign raddr      = (state == S_WALK) ? walk : qaddr;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS);
  assign prdata    = (paddr[2] == REG_RADIUS) ? CFG_DATA_W'(radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= pwdata[RADIUS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Valid marks: set on a write request, cleared only by reset
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (store_we) begin
      valid[agent_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    ctrl       = '0;
    div_start  = 1'b0;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start && (command == CMD_QUERY)) begin
          ctrl.clear = 1'b1;
          // Unknown or out-of-range agent: answer straight away with no neighbours
          state_next = (in_range && valid[agent_addr]) ? S_LOOKUP : S_DIVIDE;
        end
      end
      S_LOOKUP: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        ctrl.issue   = 1'b1;
        ctrl.hit_tag = valid[walk] && (walk != qaddr);
        // The queried entry's read data arrives in the first walk cycle
        ctrl.capture = (walk == '0);
        if (walk == ADDR_W'(SLOT_COUNT - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Hold until the last entry has left the scan pipeline
        if (!pending) begin
          div_start  = (count != '0);
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if ((count == '0) || (&div_done)) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qaddr <= agent_addr;
      walk  <= '0;
    end else if (state == S_WALK) begin
      walk <= walk + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  fnavg_store #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (agent_addr),
    .wpos  ('{y: pos_y, x: pos_x}),
    .wvel  ('{y: vel_y, x: vel_x}),
    .raddr (raddr),
    .rpos  (rpos),
    .rvel  (rvel)
  );

  fnavg_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .radius  (radius),
    .rpos    (rpos),
    .rvel    (rvel),
    .pending (pending),
    .count   (count),
    .sum_px  (sum_px),
    .sum_py  (sum_py),
    .sum_vx  (sum_vx),
    .sum_vy  (sum_vy)
  );

  assign div_num[0] = sum_px;
  assign div_num[1] = sum_py;
  assign div_num[2] = sum_vx;
  assign div_num[3] = sum_vy;

  // Four dividers run side by side on the same count
  for (genvar g = 0; g < AVG_LANES; g++) begin : g_div
    fnavg_div #(
      .CNT_W (CNT_W)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (div_num[g]),
      .divisor  (count),
      .quotient (div_q[g]),
      .done     (div_done[g])
    );
  end

  // ---------------------------------------------------------------------
  // Result registers: held until the next result, no back-pressure
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (finish) begin
      neighbor_count <= INDEX_W'(count);
      no_neighbors   <= (count == '0);
      avg_pos_x      <= (count == '0) ? '0 : div_q[0];
      avg_pos_y      <= (count == '0) ? '0 : div_q[1];
      avg_vel_x      <= (count == '0) ? '0 : div_q[2];
      avg_vel_y      <= (count == '0) ? '0 : div_q[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A result only follows the divide step
  a_done_after_divide: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DIVIDE))
    else $error("result strobe without a preceding divide step");

  // The no-neighbour flag comes with a zero count and zero averages
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && no_neighbors) |-> (neighbor_count == '0 && avg_pos_x == '0 &&
      avg_pos_y == '0 && avg_vel_x == '0 && avg_vel_y == '0))
    else $error("no_neighbors set with non-zero result fields");

  // No table entry is marked valid while a query is in progress
  a_valid_frozen: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(valid))
    else $error("valid marks changed while busy");

  // The walk ends in the drain step and never loops back
  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> (state == S_WALK || state == S_DRAIN))
    else $error("unexpected state after table walk");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for fixed_radius_neighbor_average: drives write and query requests,
// predicts every neighbour summary from its own agent table and compares the results.
// Depends on fnavg_pkg and the block's top level only.
module testbench;
  import fnavg_pkg::*;

  localparam int AGENT_SLOTS = DEFAULT_AGENT_COUNT;
  // byte addresses: the radius register, and an unused slot whose writes must be dropped
  localparam logic [CFG_ADDR_W-1:0] RADIUS_ADDR = {REG_RADIUS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR  = {~REG_RADIUS, 2'b00};
  localparam int SETTLE_CYCLES = 100;  // a little over the longest query latency

  typedef struct packed {
    logic               command;
    logic [INDEX_W-1:0] agent;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] vel_x;
    logic [COORD_W-1:0] vel_y;
  } agent_request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] count;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] vel_x;
    logic [COORD_W-1:0] vel_y;
    logic               none;
  } neighbour_summary_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       start = 1'b0;
  logic                       busy;
  logic                       command = CMD_WRITE;
  logic [INDEX_W-1:0]         agent_index = '0;
  logic signed [COORD_W-1:0]  pos_x = '0;
  logic signed [COORD_W-1:0]  pos_y = '0;
  logic signed [COORD_W-1:0]  vel_x = '0;
  logic signed [COORD_W-1:0]  vel_y = '0;
  logic                       done;
  logic [INDEX_W-1:0]         neighbor_count;
  logic signed [COORD_W-1:0]  avg_pos_x;
  logic signed [COORD_W-1:0]  avg_pos_y;
  logic signed [COORD_W-1:0]  avg_vel_x;
  logic signed [COORD_W-1:0]  avg_vel_y;
  logic                       no_neighbors;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  fixed_radius_neighbor_average i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .command(command), .agent_index(agent_index),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .done(done), .neighbor_count(neighbor_count),
    .avg_pos_x(avg_pos_x), .avg_pos_y(avg_pos_y),
    .avg_vel_x(avg_vel_x), .avg_vel_y(avg_vel_y), .no_neighbors(no_neighbors),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and neighbour summaries waiting to come back
  agent_request_t     pending_requests[$];
  neighbour_summary_t awaited_summaries[$];
  int queued_count   = 0;
  int accepted_count = 0;
  int fail_count     = 0;
  int sender_idle_pct = 0;
  logic request_taken = 1'b0;

  // Predictor's own copy of the agent table and the radius register
  logic signed [COORD_W-1:0] table_px[AGENT_SLOTS];
  logic signed [COORD_W-1:0] table_py[AGENT_SLOTS];
  logic signed [COORD_W-1:0] table_vx[AGENT_SLOTS];
  logic signed [COORD_W-1:0] table_vy[AGENT_SLOTS];
  bit                        table_live[AGENT_SLOTS];
  logic [RADIUS_W-1:0]       radius_model = RADIUS_RESET;

  // Entries the stimulus has written so far; most queries aim at these
  bit written_mask[AGENT_SLOTS];

  task automatic note_failure(string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  // Count the live agents other than the queried one that lie within the radius
  // (bounds included) and average their positions and velocities, truncating
  // toward zero; an empty neighbourhood gives zero averages and the flag.
  function automatic neighbour_summary_t neighbour_mean(int unsigned query);
    neighbour_summary_t s;
    longint sum_px, sum_py, sum_vx, sum_vy, hits, dx, dy, reach;
    s = '0;
    sum_px = 0; sum_py = 0; sum_vx = 0; sum_vy = 0; hits = 0;
    if (!table_live[query]) begin
      s.none = 1'b1;
      return s;
    end
    reach = longint'(radius_model) * longint'(radius_model);
    for (int k = 0; k < AGENT_SLOTS; k++) begin
      if (k == query || !table_live[k]) continue;
      dx = longint'(table_px[k]) - longint'(table_px[query]);
      dy = longint'(table_py[k]) - longint'(table_py[query]);
      if (dx * dx + dy * dy <= reach) begin
        sum_px += longint'(table_px[k]);
        sum_py += longint'(table_py[k]);
        sum_vx += longint'(table_vx[k]);
        sum_vy += longint'(table_vy[k]);
        hits++;
      end
    end
    s.count = INDEX_W'(hits);
    if (hits == 0) begin
      s.none = 1'b1;
    end else begin
      s.pos_x = COORD_W'(sum_px / hits);
      s.pos_y = COORD_W'(sum_py / hits);
      s.vel_x = COORD_W'(sum_vx / hits);
      s.vel_y = COORD_W'(sum_vy / hits);
    end
    return s;
  endfunction

  // Driver: present the next request at the falling edge once the previous
  // one has been taken, idling at random as the current phase asks.
  always @(negedge clk) begin : drive_requests
    agent_request_t next_req;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || request_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_req = pending_requests.pop_front();
        command     <= next_req.command;
        agent_index <= next_req.agent;
        pos_x       <= next_req.pos_x;
        pos_y       <= next_req.pos_y;
        vel_x       <= next_req.vel_x;
        vel_y       <= next_req.vel_y;
        start       <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check any result first, then track register traffic, then take
  // in a newly accepted request (a query may be taken in the cycle of a result).
  always @(posedge clk) begin : watch_block
    neighbour_summary_t seen, want;
    if (rst) begin
      request_taken <= 1'b0;
    end else begin
      if (done) begin
        seen = {neighbor_count, avg_pos_x, avg_pos_y, avg_vel_x, avg_vel_y, no_neighbors};
        if (awaited_summaries.size() == 0) begin
          note_failure($sformatf("t=%0t: result with none awaited: count %0d", $time,
                                 neighbor_count));
        end else begin
          want = awaited_summaries.pop_front();
          if (seen.count !== want.count || seen.pos_x !== want.pos_x ||
              seen.pos_y !== want.pos_y || seen.vel_x !== want.vel_x ||
              seen.vel_y !== want.vel_y || seen.none !== want.none)
            note_failure($sformatf(
              "t=%0t: wanted n=%0d p=(%0d,%0d) v=(%0d,%0d) z=%0b, got n=%0d p=(%0d,%0d) v=(%0d,%0d) z=%0b",
              $time, want.count, $signed(want.pos_x), $signed(want.pos_y),
              $signed(want.vel_x), $signed(want.vel_y), want.none,
              seen.count, $signed(seen.pos_x), $signed(seen.pos_y),
              $signed(seen.vel_x), $signed(seen.vel_y), seen.none));
        end
      end

      // Register port: follow writes to the radius, drop the rest, check reads
      if (psel && penable && pready && paddr[2] == REG_RADIUS) begin
        if (pwrite) begin
          radius_model = pwdata[RADIUS_W-1:0];
        end else if (prdata[RADIUS_W-1:0] !== radius_model) begin
          note_failure($sformatf("t=%0t: radius read %0d, wanted %0d", $time,
                                 prdata[RADIUS_W-1:0], radius_model));
        end
      end

      request_taken <= start && !busy;
      if (start && !busy) begin
        accepted_count++;
        if (command == CMD_WRITE) begin
          table_px[agent_index]   = pos_x;
          table_py[agent_index]   = pos_y;
          table_vx[agent_index]   = vel_x;
          table_vy[agent_index]   = vel_y;
          table_live[agent_index] = 1'b1;
        end else begin
          awaited_summaries.insert(awaited_summaries.size(), neighbour_mean(agent_index));
        end
      end
    end
  end

  task automatic push_write(int agent, int px, int py, int vx, int vy);
    agent_request_t r;
    r.command = CMD_WRITE;
    r.agent   = INDEX_W'(agent);
    r.pos_x   = COORD_W'(px);
    r.pos_y   = COORD_W'(py);
    r.vel_x   = COORD_W'(vx);
    r.vel_y   = COORD_W'(vy);
    written_mask[agent] = 1'b1;
    pending_requests.insert(pending_requests.size(), r);
    queued_count++;
  endtask

  task automatic push_query(int agent);
    agent_request_t r;
    r = '0;
    r.command = CMD_QUERY;
    r.agent   = INDEX_W'(agent);
    pending_requests.insert(pending_requests.size(), r);
    queued_count++;
  endtask

  // Hold until every request is taken and every result is in, then let the
  // block settle for longer than a query takes.
  task automatic wait_drained();
    while (accepted_count != queued_count || awaited_summaries.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic apb_transfer(logic is_write, logic [CFG_ADDR_W-1:0] addr,
                              logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A coordinate scattered around a centre, clamped to the Q11.4 range
  function automatic int scatter(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Random phase: mostly agents written into a cluster sized to the radius so
  // that queries find neighbours, with scattered outliers and a share of queries,
  // most of them aimed at written entries.
  task automatic random_run(int items, int unsigned radius, int idle_pct);
    int centre_x, centre_y, spread, pick, agent;
    apb_transfer(1'b1, RADIUS_ADDR, CFG_DATA_W'(radius));
    apb_transfer(1'b0, RADIUS_ADDR, '0);
    sender_idle_pct = idle_pct;
    spread = (radius * 3) / 2 + 1;
    if (spread > 32768) spread = 32768;
    centre_x = any_coord();
    centre_y = any_coord();
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(63) == 0) begin
        centre_x = any_coord();
        centre_y = any_coord();
      end
      if (pick < 35) begin
        agent = $urandom_range(AGENT_SLOTS - 1);
        if ($urandom_range(99) < 85)
          while (!written_mask[agent]) agent = $urandom_range(AGENT_SLOTS - 1);
        push_query(agent);
      end else if (pick < 88) begin
        push_write($urandom_range(AGENT_SLOTS - 1), scatter(centre_x, spread),
                   scatter(centre_y, spread), any_coord(), any_coord());
      end else begin
        push_write($urandom_range(AGENT_SLOTS - 1), any_coord(), any_coord(),
                   any_coord(), any_coord());
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset radius of 15.0 units
    push_query(5);                                  // entry never written
    push_write(0, 0, 0, 32767, -32768);
    push_query(0);                                  // alone in the table
    push_write(1, 240, 0, -32768, 32767);           // exactly on the radius
    push_write(2, 0, -240, 1, -1);                  // on the radius, other axis
    push_write(3, -1, -3, -7, 5);                   // negative sums truncate toward zero
    push_write(4, 170, 170, 11, -13);               // just outside agent 0
    push_write(63, 32767, 32767, 0, 0);             // far corners of the field
    push_write(62, -32768, -32768, -1, -1);
    push_query(0);
    push_query(63);
    push_query(4);
    push_write(1, -240, 0, 3, 3);                   // overwrite an entry
    push_query(0);
    wait_drained();

    // Widest radius: opposite corners still fall outside
    apb_transfer(1'b1, RADIUS_ADDR, 32'hFFFF_FFFF);
    apb_transfer(1'b0, RADIUS_ADDR, '0);
    push_query(63);
    push_query(62);
    push_query(0);
    wait_drained();

    // A write to the unused register slot must leave the radius alone
    apb_transfer(1'b1, SPARE_ADDR, '0);
    apb_transfer(1'b0, RADIUS_ADDR, '0);
    push_query(0);
    wait_drained();

    random_run(383, 1000, 8);
    random_run(383, 0, 80);
    random_run(383, $urandom_range(65534, 1), 0);
    random_run(383, 65535, 0);

    if (awaited_summaries.size() != 0) begin
      $display("%0d results never arrived", awaited_summaries.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
